>>> sv/dbcs_aware_line_wrapper_macros.svh
// Assertion macros for the DBCS-aware line wrapper.
`ifndef DBCS_AWARE_LINE_WRAPPER_MACROS_SVH
`define DBCS_AWARE_LINE_WRAPPER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset
`define DLW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlw assertion failed");
// Next-cycle implication, sampled on clk, off during reset
`define DLW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlw assertion failed");
`else
`define DLW_ASSERT_NOW(lbl, ante, cons)
`define DLW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/dlw_pkg.sv
// Package with constants and byte-class helpers for the DBCS-aware line wrapper.
package dlw_pkg;

  localparam int COUNT_WIDTH = 10;
  localparam int LINE_MAX_W  = 10;
  localparam int RUN_MAX     = 3;

  localparam logic [LINE_MAX_W-1:0] LINE_MAX_RESET = LINE_MAX_W'(80);

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // Configuration register indexes
  localparam logic CFG_LINE_MAX     = 1'b0;
  localparam logic CFG_NEWLINE_KIND = 1'b1;

  // Newline flavors
  localparam logic NL_LF   = 1'b0;
  localparam logic NL_CRLF = 1'b1;

  // Code page 932 lead byte range
  function automatic logic is_lead_range(input logic [7:0] b);
    is_lead_range = (b inside {[8'h81:8'h9F], [8'hE0:8'hFC]});
  endfunction

endpackage

>>> sv/dbcs_aware_line_wrapper.sv
// DBCS-aware line wrapper: Shift-JIS byte stream re-wrapped to a maximum line length.
//
// Usage:
//   in_*  : one Shift-JIS byte per request (tdata), tlast marks end of string.
//   out_* : one output byte per request (tdata); tuser flags the error result;
//           tlast marks the final result caused by one input byte.
//   cfg_* : register writes (index 0 line_max, index 1 newline_kind), always
//           ready; write only while the block is idle.
// Each accepted byte is classified and its whole result run (up to three
// bytes: newline plus text byte, or text byte plus newline) is built in the
// same cycle and loaded into a three-slot run buffer. Results leave the
// buffer one per cycle while out_tready is high, the first in the next cycle.
// Throughput: one input byte per cycle while each byte gives at most one
// result and out_tready is high; a byte that gives more results holds the
// output until the last of them leaves, and the next byte is taken in that
// cycle. The output port sets the rate. CR, LF and swallowed bytes give no
// result and are taken at once when the buffer is free.
// Reset: line_max returns to 80, newline LF, string state and buffer clear.
// Stall: while out_tready is low the buffer holds and in_tready drops once the
// buffer cannot drain in the current cycle.
module dbcs_aware_line_wrapper
  import dlw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // end_of_string
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] out_byte
  output logic                  out_tuser,  // error
  output logic                  out_tlast,  // last_of_run
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [LINE_MAX_W-1:0] cfg_data
);

`include "dbcs_aware_line_wrapper_macros.svh"

  // Configuration registers
  logic [LINE_MAX_W-1:0] line_max_r;
  logic                  newline_kind_r;

  // String state
  logic                   lead_pending_r, lead_pending_nxt;
  logic [COUNT_WIDTH-1:0] column_count_r, column_count_nxt;
  logic                   newline_due_r, newline_due_nxt;
  logic                   string_failed_r, string_failed_nxt;

  // Run buffer
  logic [7:0] run_r [RUN_MAX];
  logic [7:0] run_nxt [RUN_MAX];
  logic [1:0] run_len_r, run_len_nxt;
  logic [1:0] run_pos_r;
  logic       run_err_r, run_err_nxt;

  logic in_acc, out_acc;
  logic run_empty, run_draining;

  assign cfg_ready = 1'b1;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_max_r     <= LINE_MAX_RESET;
      newline_kind_r <= NL_LF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINE_MAX:     line_max_r     <= cfg_data;
        CFG_NEWLINE_KIND: newline_kind_r <= cfg_data[0];
        default:          line_max_r     <= line_max_r;
      endcase
    end
  end

  // Handshakes
  assign run_empty    = (run_pos_r == run_len_r);
  assign run_draining = (run_pos_r + 2'd1 == run_len_r) && out_tready;
  assign in_tready    = run_empty || run_draining;
  assign in_acc       = in_tvalid && in_tready;
  assign out_tvalid   = !run_empty;
  assign out_acc      = out_tvalid && out_tready;

  assign out_tdata = run_r[run_pos_r];
  assign out_tuser = run_err_r;
  assign out_tlast = (run_pos_r + 2'd1 == run_len_r);

  // Classify the byte, build its result run and the next string state
  always_comb begin
    logic       kept, trail_pos, lead_rng, is_lead, is_single;
    logic       nl_pre, nl_post, boundary;
    logic [1:0] k;

    lead_pending_nxt  = lead_pending_r;
    column_count_nxt  = column_count_r;
    newline_due_nxt   = newline_due_r;
    string_failed_nxt = string_failed_r;
    run_err_nxt       = 1'b0;
    for (int i = 0; i < RUN_MAX; i++) run_nxt[i] = CHAR_NUL;
    k = 2'd0;

    kept      = !string_failed_r && (in_tdata != CHAR_CR) && (in_tdata != CHAR_LF);
    trail_pos = lead_pending_r;
    lead_rng  = is_lead_range(in_tdata);
    is_lead   = !trail_pos && lead_rng;
    is_single = !trail_pos && !lead_rng;
    boundary  = (column_count_r >= COUNT_WIDTH'(line_max_r - LINE_MAX_W'(1)));
    nl_pre    = 1'b0;
    nl_post   = 1'b0;

    if (kept) begin
      lead_pending_nxt = is_lead;
      if (line_max_r <= LINE_MAX_W'(1)) begin
        newline_due_nxt  = 1'b0;
        column_count_nxt = '0;
        if (line_max_r == '0 || !is_single) begin
          string_failed_nxt = 1'b1;
          run_err_nxt       = 1'b1;
        end else begin
          nl_post = 1'b1;
        end
      end else begin
        nl_pre          = newline_due_r || (boundary && is_lead);
        newline_due_nxt = 1'b0;
        if (boundary) begin
          if (is_lead) begin
            column_count_nxt = COUNT_WIDTH'(1);
          end else begin
            newline_due_nxt  = 1'b1;
            column_count_nxt = '0;
          end
        end else begin
          column_count_nxt = column_count_r + COUNT_WIDTH'(1);
        end
      end

      // Assemble the run in order
      if (run_err_nxt) begin
        run_nxt[0] = CHAR_NUL;
        k          = 2'd1;
      end else begin
        if (nl_pre) begin
          if (newline_kind_r == NL_CRLF) begin
            run_nxt[k] = CHAR_CR;
            k          = k + 2'd1;
          end
          run_nxt[k] = CHAR_LF;
          k          = k + 2'd1;
        end
        run_nxt[k] = in_tdata;
        k          = k + 2'd1;
        if (nl_post) begin
          if (newline_kind_r == NL_CRLF) begin
            run_nxt[k] = CHAR_CR;
            k          = k + 2'd1;
          end
          run_nxt[k] = CHAR_LF;
          k          = k + 2'd1;
        end
      end
    end

    run_len_nxt = k;

    // Clear string state after its final byte
    if (in_tlast) begin
      lead_pending_nxt  = 1'b0;
      column_count_nxt  = '0;
      newline_due_nxt   = 1'b0;
      string_failed_nxt = 1'b0;
    end
  end

  // Advance string state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r  <= 1'b0;
      column_count_r  <= '0;
      newline_due_r   <= 1'b0;
      string_failed_r <= 1'b0;
    end else if (in_acc) begin
      lead_pending_r  <= lead_pending_nxt;
      column_count_r  <= column_count_nxt;
      newline_due_r   <= newline_due_nxt;
      string_failed_r <= string_failed_nxt;
    end
  end

  // Load a new run on accept, else step through the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r <= 2'd0;
      run_pos_r <= 2'd0;
    end else if (in_acc) begin
      run_len_r <= run_len_nxt;
      run_pos_r <= 2'd0;
    end else if (out_acc) begin
      run_pos_r <= run_pos_r + 2'd1;
    end
  end

  // Run payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      run_r     <= run_nxt;
      run_err_r <= run_err_nxt;
    end
  end

  // Checks
  `DLW_ASSERT_NOW(a_err_alone, out_tvalid && out_tuser, out_tlast && (out_tdata == CHAR_NUL))
  `DLW_ASSERT_NOW(a_pos_in_run, 1'b1, (run_pos_r <= run_len_r) && (run_len_r <= 2'd3))
  `DLW_ASSERT_NEXT(a_eos_clears, in_acc && in_tlast, (column_count_r == '0) && !lead_pending_r && !newline_due_r && !string_failed_r)
  `DLW_ASSERT_NOW(a_failed_idle, string_failed_r, (column_count_r == '0) && !newline_due_r)

endmodule
